### rtl/sfe_pkg.sv
package sfe_pkg;

    // step numbers of the control program
    typedef logic [2:0] step_t;

    localparam step_t STEP_WAIT  = 3'd0;
    localparam step_t STEP_CHECK = 3'd1;
    localparam step_t STEP_SRCH  = 3'd2;
    localparam step_t STEP_DIV   = 3'd3;
    localparam step_t STEP_EMIT  = 3'd4;

    // jump conditions of a control word
    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_REQ,
        COND_ERR,
        COND_SRCH_MORE,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    // one control word: datapath enables, condition, taken and fall-through targets
    typedef struct packed {
        logic  accept;
        logic  init;
        logic  srch;
        logic  div;
        logic  emit;
        cond_t cond;
        step_t jmp;
        step_t nxt;
    } ucode_t;

    // datapath flags that the sequencer tests
    typedef struct packed {
        logic req;
        logic err;
        logic srch_more;
        logic div_more;
        logic out_busy;
    } seq_status_t;

    localparam int SYM_W  = 8;
    localparam int CNT_W  = 16;
    localparam int CODE_W = 17;
    localparam int LEN_W  = 5;

    // control program
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        w.cond = COND_NONE;
        w.jmp  = STEP_WAIT;
        w.nxt  = STEP_WAIT;
        unique case (step)
            STEP_WAIT: begin
                w.accept = 1'b1;
                w.cond   = COND_NO_REQ;
                w.jmp    = STEP_WAIT;
                w.nxt    = STEP_CHECK;
            end
            STEP_CHECK: begin
                w.init = 1'b1;
                w.cond = COND_ERR;
                w.jmp  = STEP_EMIT;
                w.nxt  = STEP_SRCH;
            end
            STEP_SRCH: begin
                w.srch = 1'b1;
                w.cond = COND_SRCH_MORE;
                w.jmp  = STEP_SRCH;
                w.nxt  = STEP_DIV;
            end
            STEP_DIV: begin
                w.div  = 1'b1;
                w.cond = COND_DIV_MORE;
                w.jmp  = STEP_DIV;
                w.nxt  = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.emit = 1'b1;
                w.cond = COND_OUT_BUSY;
                w.jmp  = STEP_EMIT;
                w.nxt  = STEP_WAIT;
            end
            default: begin
                w.nxt = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/sfe_useq.sv
module sfe_useq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfe_pkg::seq_status_t status,
    output sfe_pkg::ucode_t      ctrl
);

    sfe_pkg::step_t step_reg;
    sfe_pkg::step_t step_next;
    logic           hit;

    // control word fetch
    assign ctrl = sfe_pkg::ucode_rom(step_reg);

    // condition select
    always_comb begin
        unique case (ctrl.cond)
            sfe_pkg::COND_NONE:      hit = 1'b0;
            sfe_pkg::COND_NO_REQ:    hit = ~status.req;
            sfe_pkg::COND_ERR:       hit = status.err;
            sfe_pkg::COND_SRCH_MORE: hit = status.srch_more;
            sfe_pkg::COND_DIV_MORE:  hit = status.div_more;
            sfe_pkg::COND_OUT_BUSY:  hit = status.out_busy;
            default:                 hit = 1'b0;
        endcase
    end

    assign step_next = hit ? ctrl.jmp : ctrl.nxt;

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= sfe_pkg::STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

### rtl/sfe_dpath.sv
module sfe_dpath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sfe_pkg::ucode_t             ctrl,
    output sfe_pkg::seq_status_t        status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sfe_pkg::CNT_W-1:0]   cfg_data,
    input  logic                        s_valid,
    input  logic [sfe_pkg::SYM_W-1:0]   s_symbol_value,
    input  logic [sfe_pkg::CNT_W-1:0]   s_symbol_count,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sfe_pkg::SYM_W-1:0]   m_out_symbol,
    output logic [sfe_pkg::CODE_W-1:0]  m_code_bits,
    output logic [sfe_pkg::LEN_W-1:0]   m_code_length,
    output logic                        m_error_flag
);

    localparam int KW = $clog2(COUNT_BITS + 2);
    localparam logic [KW-1:0] KMAX = KW'(COUNT_BITS);
    localparam logic [KW-1:0] KONE = KW'(1);

    logic [sfe_pkg::CNT_W-1:0]  total_reg;
    logic [COUNT_BITS-1:0]      tot;
    logic [COUNT_BITS-1:0]      cnt_reg;
    logic [COUNT_BITS-1:0]      cum_reg;
    logic [COUNT_BITS:0]        cshift_reg;
    logic [COUNT_BITS:0]        rem_reg;
    logic [KW-1:0]              k_reg;
    logic [KW-1:0]              itr_reg;
    logic [KW-1:0]              len_reg;
    logic [sfe_pkg::CODE_W-1:0] code_reg;
    logic [sfe_pkg::SYM_W-1:0]  sym_reg;
    logic                       err_reg;
    logic                       m_valid_reg;
    logic [sfe_pkg::SYM_W-1:0]  m_sym_reg;
    logic [sfe_pkg::CODE_W-1:0] m_code_reg;
    logic [sfe_pkg::LEN_W-1:0]  m_len_reg;
    logic                       m_err_reg;

    logic [COUNT_BITS:0]        sum;
    logic                       err_now;
    logic [COUNT_BITS+1:0]      den;
    logic [COUNT_BITS+1:0]      shl;
    logic [COUNT_BITS+1:0]      diff;
    logic                       ge;
    logic                       req;
    logic                       fire;

    // counts and total taken at the internal width
    assign tot = COUNT_BITS'(total_reg);

    // overrun and zero count check
    assign sum     = {1'b0, cum_reg} + {1'b0, cnt_reg};
    assign err_now = (cnt_reg == '0) || (sum > {1'b0, tot});

    // one restoring division step
    assign den  = {1'b0, tot, 1'b0};
    assign shl  = {rem_reg, 1'b0};
    assign ge   = (shl >= den);
    assign diff = shl - den;

    assign req  = s_valid & ctrl.accept;
    assign fire = ctrl.emit & ~status.out_busy;

    // flags for the sequencer
    assign status.req       = req;
    assign status.err       = err_now;
    assign status.srch_more = (k_reg < KMAX) && (cshift_reg < {1'b0, tot});
    assign status.div_more  = (itr_reg != KONE);
    assign status.out_busy  = m_valid_reg & ~m_ready;

    // control registers: total, running count, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= sfe_pkg::CNT_W'(1);
            cum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                total_reg <= cfg_data;
            end
            if (req && s_restart) begin
                cum_reg <= '0;
            end else if (fire && !err_reg) begin
                cum_reg <= sum[COUNT_BITS-1:0];
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers of the current request
    always_ff @(posedge aclk) begin
        if (req) begin
            sym_reg <= s_symbol_value;
            cnt_reg <= COUNT_BITS'(s_symbol_count);
        end
        if (ctrl.init) begin
            err_reg    <= err_now;
            cshift_reg <= {1'b0, cnt_reg};
            k_reg      <= '0;
            rem_reg    <= {cum_reg, 1'b0} + {1'b0, cnt_reg};
            code_reg   <= '0;
        end
        // length search: count shifted up until it reaches the total or the shift count reaches COUNT_BITS
        if (ctrl.srch) begin
            len_reg <= k_reg + KONE;
            itr_reg <= k_reg + KONE;
            if (status.srch_more) begin
                cshift_reg <= {cshift_reg[COUNT_BITS-1:0], 1'b0};
                k_reg      <= k_reg + KONE;
            end
        end
        // long division of the midpoint, one code bit per step
        if (ctrl.div) begin
            rem_reg  <= ge ? diff[COUNT_BITS:0] : shl[COUNT_BITS:0];
            code_reg <= {code_reg[sfe_pkg::CODE_W-2:0], ge};
            itr_reg  <= itr_reg - KONE;
        end
        // result register
        if (fire) begin
            m_sym_reg  <= sym_reg;
            m_err_reg  <= err_reg;
            m_code_reg <= err_reg ? '0 : code_reg;
            m_len_reg  <= err_reg ? '0 : sfe_pkg::LEN_W'(len_reg);
        end
    end

    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_out_symbol  = m_sym_reg;
    assign m_code_bits   = m_code_reg;
    assign m_code_length = m_len_reg;
    assign m_error_flag  = m_err_reg;

endmodule

### rtl/shannon_fano_elias_code_gen.sv
// Shannon-Fano-Elias code generator, one request at a time through a microcoded sequencer.
// A taken request passes the check, length search and division steps (L = code length, 1..17)
// before its result is registered; an error result goes from the check straight to output.
// The next request is taken only once the result has left the output step; a waiting result
// only holds the sequencer when it reaches its output step.
// Reset (aresetn, synchronous, active low): total 1, running count 0, no result pending.
module shannon_fano_elias_code_gen #(
    parameter int COUNT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sfe_pkg::CNT_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sfe_pkg::SYM_W-1:0]   s_symbol_value,
    input  logic [sfe_pkg::CNT_W-1:0]   s_symbol_count,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sfe_pkg::SYM_W-1:0]   m_out_symbol,
    output logic [sfe_pkg::CODE_W-1:0]  m_code_bits,
    output logic [sfe_pkg::LEN_W-1:0]   m_code_length,
    output logic                        m_error_flag
);

    sfe_pkg::ucode_t      ctrl;
    sfe_pkg::seq_status_t status;

    // program sequencer
    sfe_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // datapath
    sfe_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_symbol_value (s_symbol_value),
        .s_symbol_count (s_symbol_count),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_symbol   (m_out_symbol),
        .m_code_bits    (m_code_bits),
        .m_code_length  (m_code_length),
        .m_error_flag   (m_error_flag)
    );

    assign s_ready = ctrl.accept;

endmodule

### rtl/sfe_chk.sv
module sfe_chk (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [sfe_pkg::SYM_W-1:0]   m_out_symbol,
    input logic [sfe_pkg::CODE_W-1:0]  m_code_bits,
    input logic [sfe_pkg::LEN_W-1:0]   m_code_length,
    input logic                        m_error_flag
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_symbol) && $stable(m_code_bits)
            && $stable(m_code_length) && $stable(m_error_flag))
        else $error("stalled result changed");

    // one request at a time
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while one is in work");

    // error result is empty
    a_err_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_flag |-> m_code_length == '0 && m_code_bits == '0)
        else $error("error result carries a code");

    // good result has a length in range
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error_flag |-> m_code_length != '0 && m_code_length <= 5'd17)
        else $error("code length out of range");

    // code fits in its length
    a_code_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error_flag |-> (m_code_bits >> m_code_length) == '0)
        else $error("code wider than its length");

endmodule

bind shannon_fano_elias_code_gen sfe_chk u_sfe_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_symbol  (m_out_symbol),
    .m_code_bits   (m_code_bits),
    .m_code_length (m_code_length),
    .m_error_flag  (m_error_flag)
);

### sim/testbench.sv
module testbench;

    localparam int SYM_W        = sfe_pkg::SYM_W;
    localparam int CNT_W        = sfe_pkg::CNT_W;
    localparam int CODE_W       = sfe_pkg::CODE_W;
    localparam int LEN_W        = sfe_pkg::LEN_W;

    localparam int COUNT_BITS   = 16;
    localparam int ITEM_TARGET  = 950;
    localparam int CALM_ITEMS   = 150;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 40;

    // one codeword as it leaves the block
    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              err;
    } codeword_t;

    // running cumulative count, message total and the codewords still owed
    class codeword_board;
        logic [CNT_W-1:0] total_reg;
        logic [CNT_W-1:0] running_sum;
        codeword_t        owed_codes[$];
        int               errors;
        int               checked;
        int               error_results;

        function new();
            total_reg     = 16'd1;
            running_sum   = '0;
            errors        = 0;
            checked       = 0;
            error_results = 0;
        endfunction

        function void set_total(input logic [CNT_W-1:0] value);
            total_reg = value;
        endfunction

        function int pending();
            return owed_codes.size();
        endfunction

        // exact midpoint expansion by restoring division
        function void note_symbol(input logic [SYM_W-1:0] sym,
                                  input logic [CNT_W-1:0] cnt,
                                  input logic rst);
            codeword_t        c;
            logic [CNT_W:0]   reach;
            logic [63:0]      num;
            logic [63:0]      den;
            int unsigned      k;
            if (rst) begin
                running_sum = '0;
            end
            c.sym  = sym;
            c.bits = '0;
            c.len  = '0;
            c.err  = 1'b0;
            reach  = {1'b0, running_sum} + {1'b0, cnt};
            if (cnt == '0 || reach > {1'b0, total_reg}) begin
                c.err = 1'b1;
            end else begin
                k = 0;
                while (k < COUNT_BITS && (64'(cnt) << k) < 64'(total_reg)) begin
                    k++;
                end
                c.len = LEN_W'(k + 1);
                num   = 2 * 64'(running_sum) + 64'(cnt);
                den   = 2 * 64'(total_reg);
                for (int i = 0; i <= int'(k); i++) begin
                    num    = num << 1;
                    c.bits = c.bits << 1;
                    if (num >= den) begin
                        num       = num - den;
                        c.bits[0] = 1'b1;
                    end
                end
                running_sum = reach[CNT_W-1:0];
            end
            owed_codes.insert(owed_codes.size(), c);
        endfunction

        function void check_code(input codeword_t got);
            codeword_t want;
            if (owed_codes.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: unexpected result, symbol %h code %h length %0d error %b",
                             $time, got.sym, got.bits, got.len, got.err);
                end
                return;
            end
            want = owed_codes.pop_front();
            checked++;
            if (got.err) begin
                error_results++;
            end
            if (got.sym !== want.sym) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: out_symbol expected %h actual %h",
                             $time, want.sym, got.sym);
                end
            end
            if (got.bits !== want.bits) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: code_bits expected %h actual %h (symbol %h)",
                             $time, want.bits, got.bits, want.sym);
                end
            end
            if (got.len !== want.len) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: code_length expected %0d actual %0d (symbol %h)",
                             $time, want.len, got.len, want.sym);
                end
            end
            if (got.err !== want.err) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("%0t: error_flag expected %b actual %b (symbol %h)",
                             $time, want.err, got.err, want.sym);
                end
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic [SYM_W-1:0]  s_symbol_value;
    logic [CNT_W-1:0]  s_symbol_count;
    logic              s_restart;
    logic              m_valid;
    logic              m_ready;
    logic [SYM_W-1:0]  m_out_symbol;
    logic [CODE_W-1:0] m_code_bits;
    logic [LEN_W-1:0]  m_code_length;
    logic              m_error_flag;

    codeword_board board;
    int            items_sent;
    int            cfg_writes;
    int            idle_cycles = 0;
    bit            calm;
    bit            hold_request;
    bit            hold_done;
    bit            pause_done;

    shannon_fano_elias_code_gen dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_symbol_value (s_symbol_value),
        .s_symbol_count (s_symbol_count),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_symbol   (m_out_symbol),
        .m_code_bits    (m_code_bits),
        .m_code_length  (m_code_length),
        .m_error_flag   (m_error_flag)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_code({m_out_symbol, m_code_bits, m_code_length, m_error_flag});
        end
    end

    // stall watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, board.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result sink: random back-pressure bursts and one long hold-off
    initial begin : sink
        int quiet;
        quiet   = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_request = 1'b0;
            end else if (quiet > 0) begin
                m_ready <= 1'b0;
                quiet--;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                quiet = $urandom_range(1, 16) - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // one symbol request, with an occasional gap in front of it
    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic [CNT_W-1:0] cnt,
                               input logic rst);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_symbol_value <= sym;
        s_symbol_count <= cnt;
        s_restart      <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_symbol(sym, cnt, rst);
        items_sent++;
    endtask

    // stop offering and wait for every owed codeword
    task automatic drain_results(input int settle);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_total(input logic [CNT_W-1:0] value);
        drain_results(SETTLE);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.set_total(value);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one message whose counts add up to the total, with some noise and early breaks
    task automatic send_message(input logic [CNT_W-1:0] tot);
        int unsigned remaining;
        int unsigned cnt;
        int          sym_limit;
        int          n;
        logic        rst;
        remaining = tot;
        sym_limit = $urandom_range(1, 12);
        n         = 0;
        rst       = 1'b1;
        while (remaining > 0 && items_sent < ITEM_TARGET) begin
            if (!pause_done && items_sent >= 600 && !rst) begin
                drain_results(0);
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                // zero count or an overrun of the total
                if (remaining < 65535 && $urandom_range(0, 1) == 1) begin
                    cnt = $urandom_range(remaining + 1, 65535);
                end else begin
                    cnt = 0;
                end
                send_symbol(SYM_W'($urandom), CNT_W'(cnt), rst);
            end else begin
                if (n + 1 >= sym_limit) begin
                    cnt = remaining;
                end else begin
                    cnt = 1 + ($urandom % (32'd1 << $urandom_range(0, 16)));
                    if (cnt > remaining) begin
                        cnt = $urandom_range(1, remaining);
                    end
                end
                send_symbol(SYM_W'($urandom), CNT_W'(cnt), rst);
                remaining -= cnt;
                n++;
            end
            rst = 1'b0;
            if ($urandom_range(0, 29) == 0) begin
                break;
            end
        end
    endtask

    // stimulus
    initial begin : stimulus
        logic [CNT_W-1:0] tot;
        int               pick;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_symbol_value = '0;
        s_symbol_count = '0;
        s_restart      = 1'b0;
        items_sent     = 0;
        cfg_writes     = 0;
        calm           = 1'b0;
        hold_request   = 1'b0;
        hold_done      = 1'b0;
        pause_done     = 1'b0;
        board          = new();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // total of one after reset: single symbol, overrun, zero count with restart, restarted single symbol
        send_symbol(8'h00, 16'd1, 1'b0);
        send_symbol(8'hFF, 16'd1, 1'b0);
        send_symbol(8'h5A, 16'd0, 1'b1);
        send_symbol(8'hA5, 16'd1, 1'b1);

        // largest total: shortest and longest codes, filling it to the brim, and overruns
        write_total(16'hFFFF);
        send_symbol(8'hA5, 16'hFFFF, 1'b1);
        send_symbol(8'h01, 16'd1, 1'b0);
        send_symbol(8'h02, 16'd1, 1'b1);
        send_symbol(8'h03, 16'hFFFE, 1'b0);
        send_symbol(8'h04, 16'hFFFF, 1'b0);
        send_symbol(8'h55, 16'h5555, 1'b1);
        send_symbol(8'hAA, 16'hAAAA, 1'b0);

        // zero total: everything is an error
        write_total(16'd0);
        send_symbol(8'h10, 16'd1, 1'b1);
        send_symbol(8'h11, 16'd0, 1'b0);
        send_symbol(8'h12, 16'hFFFF, 1'b1);

        // three equal symbols, then one too many
        write_total(16'd3);
        send_symbol(8'h20, 16'd1, 1'b1);
        send_symbol(8'h21, 16'd1, 1'b0);
        send_symbol(8'h22, 16'd1, 1'b0);
        send_symbol(8'h23, 16'd1, 1'b0);

        // random messages over random totals
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                tot = 16'hFFFF;
            end else if (pick == 1) begin
                tot = 16'd1;
            end else if (pick == 2) begin
                tot = 16'd0;
            end else if (pick <= 8) begin
                tot = CNT_W'($urandom_range(2, 400));
            end else begin
                tot = CNT_W'($urandom_range(2, 65535));
            end
            write_total(tot);
            if (!hold_done && items_sent >= 300) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (tot == '0) begin
                repeat (4) send_symbol(SYM_W'($urandom), CNT_W'($urandom),
                                       1'($urandom));
            end else begin
                repeat ($urandom_range(2, 5)) begin
                    calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
                    send_message(tot);
                end
            end
            calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
        end

        drain_results(SETTLE);
        $display("sent %0d symbols under %0d total settings; %0d codewords checked",
                 items_sent, cfg_writes, board.checked);
        $display("%0d of those were error results (zero count, overrun or zero total)",
                 board.error_results);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
rtl/sfe_pkg.sv
rtl/sfe_useq.sv
rtl/sfe_dpath.sv
rtl/shannon_fano_elias_code_gen.sv
rtl/sfe_chk.sv
sim/testbench.sv
